// ===== hw/rtl/ppp_pik_pkg.sv =====
// ----------------------------------------------------------------------------
// ppp_pik_pkg
// Shared types and constants for the pair interaction kernel pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package ppp_pik_pkg;

    // fixed point format of all values
    localparam int FRAC_BITS = 16;
    localparam int INT_BITS  = 8;
    localparam int TOT_BITS  = INT_BITS + FRAC_BITS;

    localparam logic [TOT_BITS-1:0] VAL_MAX = {TOT_BITS{1'b1}};
    localparam logic [TOT_BITS-1:0] ONE_Q   = TOT_BITS'(1) << FRAC_BITS;

    // sqrt(0.6117) * 0.529177249 in Q0.32
    localparam logic [31:0] SQRTK_Q32    = 32'd1777584548;
    // inverse of the same-site limit in bohr
    localparam logic [9:0]  SAMESITE_INV = 10'd1000;

    // internal widths
    localparam int SUM_W   = TOT_BITS + 1;        // u1 + u2
    localparam int A_W     = 2 * FRAC_BITS + 2;   // 2^(2F+1) / sum
    localparam int DEN0_W  = A_W + 1;             // d + a
    localparam int SQ_IN_W = 31;                  // hypot operands after scaling
    localparam int RAD_W   = 64;                  // radicand
    localparam int ROOT_W  = RAD_W / 2;
    localparam int H_W     = ROOT_W + 3;          // root after scaling back
    localparam int QN_W    = TOT_BITS + FRAC_BITS; // final numerator
    localparam int QD_W    = 36;                  // final divisor

    // register indexes
    localparam logic [0:0] REG_KERNEL_MODE = 1'b0;
    localparam logic [0:0] REG_DIELECTRIC  = 1'b1;

    typedef enum logic [1:0] {
        MODE_MN       = 2'd0,
        MODE_OHNO     = 2'd1,
        MODE_COULOMB  = 2'd2,
        MODE_SCREENED = 2'd3
    } kernel_mode_t;

    // per-item context carried down the front half of the pipeline
    typedef struct packed {
        kernel_mode_t          mode;
        logic [TOT_BITS-1:0]   distance;
        logic [TOT_BITS-1:0]   mean;
        logic [TOT_BITS-1:0]   diel;
        logic                  inf;
        logic                  close;
        logic                  near;
        logic [DEN0_W-1:0]     den0;
        logic [1:0]            shift;
    } item_t;

    // result context carried through the final divider
    typedef struct packed {
        logic                  bypass;
        logic [TOT_BITS-1:0]   byp_val;
        logic                  close;
        logic                  sat;
    } tail_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ppp_pik_div_pipe.sv =====
// ----------------------------------------------------------------------------
// ppp_pik_div_pipe
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// ----------------------------------------------------------------------------
`default_nettype none

module ppp_pik_div_pipe #(
    parameter int NUM_W  = 34,
    parameter int DEN_W  = 25,
    parameter int SIDE_W = 1
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              adv,
    input  wire logic              in_valid,
    input  wire logic [NUM_W-1:0]  in_num,
    input  wire logic [DEN_W-1:0]  in_den,
    input  wire logic [SIDE_W-1:0] in_side,
    output logic                   out_valid,
    output logic [NUM_W-1:0]       out_quo,
    output logic [SIDE_W-1:0]      out_side
);

    logic              v_reg    [NUM_W];
    logic [DEN_W-1:0]  rem_reg  [NUM_W];
    logic [NUM_W-1:0]  num_reg  [NUM_W];
    logic [NUM_W-1:0]  quo_reg  [NUM_W];
    logic [DEN_W-1:0]  den_reg  [NUM_W];
    logic [SIDE_W-1:0] side_reg [NUM_W];

    for (genvar g = 0; g < NUM_W; g++) begin : g_stage
        logic              v_in;
        logic [DEN_W-1:0]  rem_in;
        logic [NUM_W-1:0]  num_in;
        logic [NUM_W-1:0]  quo_in;
        logic [DEN_W-1:0]  den_in;
        logic [SIDE_W-1:0] side_in;
        logic [DEN_W:0]    trial;
        logic [DEN_W:0]    diff;
        logic              ge;

        // stage inputs
        if (g == 0) begin : g_first
            assign v_in    = in_valid;
            assign rem_in  = '0;
            assign num_in  = in_num;
            assign quo_in  = '0;
            assign den_in  = in_den;
            assign side_in = in_side;
        end else begin : g_next
            assign v_in    = v_reg[g-1];
            assign rem_in  = rem_reg[g-1];
            assign num_in  = num_reg[g-1];
            assign quo_in  = quo_reg[g-1];
            assign den_in  = den_reg[g-1];
            assign side_in = side_reg[g-1];
        end

        // shift in one numerator bit, subtract when it fits
        assign trial = {rem_in, num_in[NUM_W-1]};
        assign diff  = trial - {1'b0, den_in};
        assign ge    = (trial >= {1'b0, den_in});

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[g] <= 1'b0;
            end else if (adv) begin
                v_reg[g] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                rem_reg[g]  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                num_reg[g]  <= num_in << 1;
                quo_reg[g]  <= {quo_in[NUM_W-2:0], ge};
                den_reg[g]  <= den_in;
                side_reg[g] <= side_in;
            end
        end
    end

    assign out_valid = v_reg[NUM_W-1];
    assign out_quo   = quo_reg[NUM_W-1];
    assign out_side  = side_reg[NUM_W-1];

endmodule

`default_nettype wire

// ===== hw/rtl/ppp_pair_interaction_kernel_top.sv =====
// Pipeline: input register, 34-stage divider for a, four setup stages, 32-stage
// square root, two stages, 40-stage divider for the result, output register.
// Throughput: one transaction per cycle; the pipeline stalls as a whole only when
// the output register is full and not taken and the last divider stage is valid.
// Reset: valid bits cleared, kernel_mode back to Mataga-Nishimoto, dielectric 1.0.
// ----------------------------------------------------------------------------
// ppp_pair_interaction_kernel_top
// Two-site PPP interaction energy with four selectable kernels, fully pipelined.
// ----------------------------------------------------------------------------
`default_nettype none

module ppp_pair_interaction_kernel_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration write port
    input  wire logic        cfg_wr_en,
    input  wire logic [0:0]  cfg_addr,
    input  wire logic [23:0] cfg_wdata,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [71:0] s_tdata,   // u_first[23:0], u_second[47:24], distance[71:48]
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata    // interaction[23:0], too_close[24], saturated[25]
);

    localparam int TB     = ppp_pik_pkg::TOT_BITS;
    localparam int FB     = ppp_pik_pkg::FRAC_BITS;
    localparam int SUM_W  = ppp_pik_pkg::SUM_W;
    localparam int A_W    = ppp_pik_pkg::A_W;
    localparam int DEN0_W = ppp_pik_pkg::DEN0_W;
    localparam int SQ_W   = ppp_pik_pkg::SQ_IN_W;
    localparam int RAD_W  = ppp_pik_pkg::RAD_W;
    localparam int ROOT_W = ppp_pik_pkg::ROOT_W;
    localparam int H_W    = ppp_pik_pkg::H_W;
    localparam int QN_W   = ppp_pik_pkg::QN_W;
    localparam int QD_W   = ppp_pik_pkg::QD_W;
    localparam int ITEM_W = $bits(ppp_pik_pkg::item_t);
    localparam int TAIL_W = $bits(ppp_pik_pkg::tail_t);

    localparam logic [A_W-1:0]  A_NUM    = A_W'(1) << (2 * FB + 1);
    localparam logic [QN_W-1:0] INV_NUM  = QN_W'(1) << (2 * FB);
    localparam logic [33:0]     LIMIT_Q  = 34'(ppp_pik_pkg::ONE_Q);

    // ------------------------------------------------------------------
    // flow control
    // ------------------------------------------------------------------
    logic out_free;
    logic adv;
    logic divb_v;
    logic m_tvalid_reg;

    assign out_free = !m_tvalid_reg || m_tready;
    assign adv      = out_free || !divb_v;
    assign s_tready = adv;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    ppp_pik_pkg::kernel_mode_t mode_reg;
    logic [TB-1:0]             diel_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= ppp_pik_pkg::MODE_MN;
            diel_reg <= ppp_pik_pkg::ONE_Q;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                ppp_pik_pkg::REG_KERNEL_MODE: begin
                    mode_reg <= ppp_pik_pkg::kernel_mode_t'(cfg_wdata[1:0]);
                end
                ppp_pik_pkg::REG_DIELECTRIC: begin
                    diel_reg <= cfg_wdata;
                end
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // input register: sum, mean and range classification
    // ------------------------------------------------------------------
    logic [TB-1:0]       in_u1, in_u2, in_d;
    logic [SUM_W-1:0]    in_sum;
    logic [33:0]         in_dk;
    ppp_pik_pkg::item_t  s0_item_next, s0_item_reg;
    logic [SUM_W-1:0]    s0_sum_reg;
    logic                s0_v_reg;

    always_comb begin
        in_u1  = s_tdata[23:0];
        in_u2  = s_tdata[47:24];
        in_d   = s_tdata[71:48];
        in_sum = {1'b0, in_u1} + {1'b0, in_u2};
        in_dk  = 34'(in_d) * 34'(ppp_pik_pkg::SAMESITE_INV);
        s0_item_next          = '0;
        s0_item_next.mode     = mode_reg;
        s0_item_next.distance = in_d;
        s0_item_next.mean     = in_sum[SUM_W-1:1];
        s0_item_next.diel     = diel_reg;
        s0_item_next.inf   = ((mode_reg == ppp_pik_pkg::MODE_MN) ||
                              (mode_reg == ppp_pik_pkg::MODE_OHNO)) && (in_sum == '0);
        s0_item_next.close = (mode_reg == ppp_pik_pkg::MODE_COULOMB) && (in_dk < LIMIT_Q);
        s0_item_next.near  = (mode_reg == ppp_pik_pkg::MODE_SCREENED) &&
                             !(in_dk > LIMIT_Q);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_v_reg <= 1'b0;
        end else if (adv) begin
            s0_v_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s0_item_reg <= s0_item_next;
            s0_sum_reg  <= in_sum;
        end
    end

    // ------------------------------------------------------------------
    // a = 2^(2F+1) / (u1 + u2)
    // ------------------------------------------------------------------
    logic               diva_v;
    logic [A_W-1:0]     diva_quo;
    logic [ITEM_W-1:0]  diva_side;
    ppp_pik_pkg::item_t diva_item;

    ppp_pik_div_pipe #(
        .NUM_W  (A_W),
        .DEN_W  (SUM_W),
        .SIDE_W (ITEM_W)
    ) u_div_a (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (s0_v_reg),
        .in_num    (A_NUM),
        .in_den    ((s0_sum_reg == '0) ? SUM_W'(1) : s0_sum_reg),
        .in_side   (s0_item_reg),
        .out_valid (diva_v),
        .out_quo   (diva_quo),
        .out_side  (diva_side)
    );

    assign diva_item = diva_side;

    // ------------------------------------------------------------------
    // p2: d + a, hypot scaling, d * sqrt(k) partial products
    // ------------------------------------------------------------------
    ppp_pik_pkg::item_t p2_item_next, p2_item_reg;
    logic [A_W-1:0]     p2_a_reg;
    logic [39:0]        p2_phi_reg;
    logic [47:0]        p2_plo_reg;
    logic               p2_v_reg;

    always_comb begin
        p2_item_next      = diva_item;
        p2_item_next.den0 = DEN0_W'(diva_item.distance) + DEN0_W'(diva_quo);
        // only the ohno hypot has a wide operand; the screened one needs no scaling
        if (diva_item.mode != ppp_pik_pkg::MODE_OHNO) begin
            p2_item_next.shift = 2'd0;
        end else if (diva_quo[A_W-1]) begin
            p2_item_next.shift = 2'd3;
        end else if (diva_quo[A_W-2]) begin
            p2_item_next.shift = 2'd2;
        end else if (diva_quo[A_W-3]) begin
            p2_item_next.shift = 2'd1;
        end else begin
            p2_item_next.shift = 2'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_v_reg <= 1'b0;
        end else if (adv) begin
            p2_v_reg <= diva_v;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p2_item_reg <= p2_item_next;
            p2_a_reg    <= diva_quo;
            p2_phi_reg  <= 40'(diva_item.distance[23:16]) * 40'(ppp_pik_pkg::SQRTK_Q32);
            p2_plo_reg  <= 48'(diva_item.distance[15:0]) * 48'(ppp_pik_pkg::SQRTK_Q32);
        end
    end

    // ------------------------------------------------------------------
    // p3: hypot operands per kernel
    // ------------------------------------------------------------------
    logic [40:0]        p3_msum;
    logic [SQ_W-1:0]    p3_xs_next, p3_ys_next;
    logic [SQ_W-1:0]    p3_xs_reg, p3_ys_reg;
    logic [A_W-1:0]     p3_as;
    logic [TB-1:0]      p3_ds;
    ppp_pik_pkg::item_t p3_item_reg;
    logic               p3_v_reg;

    always_comb begin
        p3_msum = 41'(p2_phi_reg) + 41'(p2_plo_reg[47:16]);
        p3_as   = p2_a_reg >> p2_item_reg.shift;
        p3_ds   = p2_item_reg.distance >> p2_item_reg.shift;
        case (p2_item_reg.mode)
            ppp_pik_pkg::MODE_OHNO: begin
                p3_xs_next = SQ_W'(p3_ds);
                p3_ys_next = p3_as[SQ_W-1:0];
            end
            ppp_pik_pkg::MODE_SCREENED: begin
                p3_xs_next = SQ_W'(ppp_pik_pkg::ONE_Q);
                p3_ys_next = SQ_W'(p3_msum[40:16]);
            end
            default: begin
                p3_xs_next = '0;
                p3_ys_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p3_v_reg <= 1'b0;
        end else if (adv) begin
            p3_v_reg <= p2_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p3_item_reg <= p2_item_reg;
            p3_xs_reg   <= p3_xs_next;
            p3_ys_reg   <= p3_ys_next;
        end
    end

    // ------------------------------------------------------------------
    // p4: squares
    // ------------------------------------------------------------------
    logic [2*SQ_W-1:0]  p4_sqx_reg, p4_sqy_reg;
    ppp_pik_pkg::item_t p4_item_reg;
    logic               p4_v_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p4_v_reg <= 1'b0;
        end else if (adv) begin
            p4_v_reg <= p3_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p4_item_reg <= p3_item_reg;
            p4_sqx_reg  <= p3_xs_reg * p3_xs_reg;
            p4_sqy_reg  <= p3_ys_reg * p3_ys_reg;
        end
    end

    // ------------------------------------------------------------------
    // p5: radicand
    // ------------------------------------------------------------------
    logic [RAD_W-1:0]   p5_rad_reg;
    ppp_pik_pkg::item_t p5_item_reg;
    logic               p5_v_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p5_v_reg <= 1'b0;
        end else if (adv) begin
            p5_v_reg <= p4_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p5_item_reg <= p4_item_reg;
            p5_rad_reg  <= RAD_W'(p4_sqx_reg) + RAD_W'(p4_sqy_reg);
        end
    end

    // ------------------------------------------------------------------
    // integer square root, one result bit per stage
    // ------------------------------------------------------------------
    logic               sq_v_reg    [ROOT_W];
    logic [ROOT_W:0]    sq_rem_reg  [ROOT_W];
    logic [ROOT_W-1:0]  sq_root_reg [ROOT_W];
    logic [RAD_W-1:0]   sq_rad_reg  [ROOT_W];
    ppp_pik_pkg::item_t sq_item_reg [ROOT_W];

    for (genvar g = 0; g < ROOT_W; g++) begin : g_sqrt
        logic               v_in;
        logic [ROOT_W:0]    rem_in;
        logic [ROOT_W-1:0]  root_in;
        logic [RAD_W-1:0]   rad_in;
        ppp_pik_pkg::item_t item_in;
        logic [ROOT_W+2:0]  trial;
        logic [ROOT_W+2:0]  tval;
        logic [ROOT_W+2:0]  diff;
        logic               ge;

        // stage inputs
        if (g == 0) begin : g_first
            assign v_in    = p5_v_reg;
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = p5_rad_reg;
            assign item_in = p5_item_reg;
        end else begin : g_next
            assign v_in    = sq_v_reg[g-1];
            assign rem_in  = sq_rem_reg[g-1];
            assign root_in = sq_root_reg[g-1];
            assign rad_in  = sq_rad_reg[g-1];
            assign item_in = sq_item_reg[g-1];
        end

        // bring down two radicand bits, try 4r+1
        assign trial = {rem_in, rad_in[RAD_W-1:RAD_W-2]};
        assign tval  = {1'b0, root_in, 2'b01};
        assign diff  = trial - tval;
        assign ge    = (trial >= tval);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sq_v_reg[g] <= 1'b0;
            end else if (adv) begin
                sq_v_reg[g] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                sq_rem_reg[g]  <= ge ? diff[ROOT_W:0] : trial[ROOT_W:0];
                sq_root_reg[g] <= {root_in[ROOT_W-2:0], ge};
                sq_rad_reg[g]  <= rad_in << 2;
                sq_item_reg[g] <= item_in;
            end
        end
    end

    // ------------------------------------------------------------------
    // p6: scale root back, dielectric partial products
    // ------------------------------------------------------------------
    logic [H_W-1:0]     p6_h;
    logic [H_W-1:0]     p6_h_reg;
    logic [H_W+7:0]     p6_dhi_reg;
    logic [H_W+15:0]    p6_dlo_reg;
    ppp_pik_pkg::item_t p6_item_reg;
    logic               p6_v_reg;

    assign p6_h = H_W'(sq_root_reg[ROOT_W-1]) << sq_item_reg[ROOT_W-1].shift;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p6_v_reg <= 1'b0;
        end else if (adv) begin
            p6_v_reg <= sq_v_reg[ROOT_W-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p6_item_reg <= sq_item_reg[ROOT_W-1];
            p6_h_reg    <= p6_h;
            p6_dhi_reg  <= (H_W+8)'(sq_item_reg[ROOT_W-1].diel[23:16]) * (H_W+8)'(p6_h);
            p6_dlo_reg  <= (H_W+16)'(sq_item_reg[ROOT_W-1].diel[15:0]) * (H_W+16)'(p6_h);
        end
    end

    // ------------------------------------------------------------------
    // p7: select final numerator and divisor, or a direct result
    // ------------------------------------------------------------------
    logic [H_W+8:0]       p7_den3;
    logic [QN_W-1:0]      p7_num_next, p7_num_reg;
    logic [QD_W-1:0]      p7_den_next, p7_den_reg;
    ppp_pik_pkg::tail_t   p7_tail_next, p7_tail_reg;
    logic                 p7_v_reg;

    always_comb begin
        p7_den3      = (H_W+9)'(p6_dhi_reg) + (H_W+9)'(p6_dlo_reg[H_W+15:16]);
        p7_num_next  = INV_NUM;
        p7_den_next  = '0;
        p7_tail_next = '0;
        case (p6_item_reg.mode)
            ppp_pik_pkg::MODE_MN: begin
                p7_den_next = QD_W'(p6_item_reg.den0);
            end
            ppp_pik_pkg::MODE_OHNO: begin
                p7_den_next = QD_W'(p6_h_reg);
            end
            ppp_pik_pkg::MODE_COULOMB: begin
                p7_den_next = QD_W'(p6_item_reg.distance);
            end
            ppp_pik_pkg::MODE_SCREENED: begin
                p7_num_next = {p6_item_reg.mean, FB'(0)};
                p7_den_next = (p7_den3 > (H_W+9)'({QD_W{1'b1}})) ? {QD_W{1'b1}}
                                                                : QD_W'(p7_den3);
            end
            default: begin
            end
        endcase
        // direct results
        if (p6_item_reg.inf) begin
            p7_tail_next.bypass  = 1'b1;
            p7_tail_next.byp_val = ppp_pik_pkg::VAL_MAX;
            p7_tail_next.sat     = 1'b1;
        end else if (p6_item_reg.close) begin
            p7_tail_next.bypass  = 1'b1;
            p7_tail_next.close   = 1'b1;
        end else if (p6_item_reg.near) begin
            p7_tail_next.bypass  = 1'b1;
            p7_tail_next.byp_val = p6_item_reg.mean;
        end else if (p7_den_next == '0) begin
            p7_tail_next.bypass  = 1'b1;
            p7_tail_next.byp_val = ppp_pik_pkg::VAL_MAX;
            p7_tail_next.sat     = 1'b1;
        end
        if (p7_tail_next.bypass) begin
            p7_den_next = QD_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p7_v_reg <= 1'b0;
        end else if (adv) begin
            p7_v_reg <= p6_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p7_num_reg  <= p7_num_next;
            p7_den_reg  <= p7_den_next;
            p7_tail_reg <= p7_tail_next;
        end
    end

    // ------------------------------------------------------------------
    // final quotient
    // ------------------------------------------------------------------
    logic [QN_W-1:0]    divb_quo;
    logic [TAIL_W-1:0]  divb_side;
    ppp_pik_pkg::tail_t divb_tail;

    ppp_pik_div_pipe #(
        .NUM_W  (QN_W),
        .DEN_W  (QD_W),
        .SIDE_W (TAIL_W)
    ) u_div_b (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (p7_v_reg),
        .in_num    (p7_num_reg),
        .in_den    (p7_den_reg),
        .in_side   (p7_tail_reg),
        .out_valid (divb_v),
        .out_quo   (divb_quo),
        .out_side  (divb_side)
    );

    assign divb_tail = divb_side;

    // ------------------------------------------------------------------
    // saturation and output register
    // ------------------------------------------------------------------
    logic [31:0] m_tdata_next, m_tdata_reg;

    always_comb begin
        m_tdata_next = '0;
        if (divb_tail.bypass) begin
            m_tdata_next[23:0] = divb_tail.byp_val;
            m_tdata_next[24]   = divb_tail.close;
            m_tdata_next[25]   = divb_tail.sat;
        end else if (divb_quo > QN_W'(ppp_pik_pkg::VAL_MAX)) begin
            m_tdata_next[23:0] = ppp_pik_pkg::VAL_MAX;
            m_tdata_next[25]   = 1'b1;
        end else begin
            m_tdata_next[23:0] = divb_quo[TB-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_free) begin
            m_tvalid_reg <= divb_v;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire
